### hw/rtl/id3pts_pkg.sv
// ----------------------------------------------------------------------------
// id3pts_pkg
// Constants, codes and lookup functions for the ID3 PRIV timestamp parser.
// ----------------------------------------------------------------------------
package id3pts_pkg;

  localparam int HDR_LEN   = 10;
  localparam int PRIV_LEN  = 53;
  localparam int OWNER_LEN = 44;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // result status codes
  localparam logic [1:0] ST_TAG_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_NO_TAG    = 2'd2;

  localparam logic [23:0] MAGIC_STR = "ID3";
  localparam logic [31:0] PRIV_STR  = "PRIV";
  // transport stream timestamp owner string, ASCII, first character in the MSBs
  localparam logic [8*OWNER_LEN-1:0] OWNER_STR = {
    32'h636f6d2e, 32'h6170706c, 32'h652e7374, 32'h7265616d,
    32'h696e672e, 32'h7472616e, 32'h73706f72, 32'h74537472,
    32'h65616d54, 32'h696d6573, 32'h74616d70};

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FRAME  = 3'd1,
    PH_BODY   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_HALT   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [63:0] ts;
    logic [1:0]  status;
    logic        fresh;
    logic        last;
  } out_item_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = MAGIC_STR[23:16];
      2'd1:    b = MAGIC_STR[15:8];
      2'd2:    b = MAGIC_STR[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] priv_byte(input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = PRIV_STR[31:24];
      2'd1:    b = PRIV_STR[23:16];
      2'd2:    b = PRIV_STR[15:8];
      default: b = PRIV_STR[7:0];
    endcase
    return b;
  endfunction

  // valid for i below OWNER_LEN
  function automatic logic [7:0] owner_byte(input logic [5:0] i);
    logic [8*OWNER_LEN-1:0] s;
    s = OWNER_STR << (8 * i);
    return s[8*OWNER_LEN-1 -: 8];
  endfunction

endpackage

### hw/rtl/id3_priv_timestamp_parser_unit.sv
// ----------------------------------------------------------------------------
// id3_priv_timestamp_parser_unit
// Byte-serial ID3v2 tag scanner that extracts a PRIV stream timestamp.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per transfer on in_tdata; a transfer with
// in_tlast set marks end of stream (its data byte is ignored), closes the
// current parse and re-arms the parser for a new tag.
// Output channel: status results. out_tdata carries the latest timestamp,
// out_tuser the status and the new-timestamp flag, out_tlast marks the last
// result caused by one input transfer (end of stream can cause two).
// Throughput: one input byte per cycle. The parse state is updated in the
// cycle a byte is taken; its results enter a four-entry result queue at the
// accepting edge and are shown on the output from the head of the queue.
// in_tready is high while the queue has room for two results, so with an
// output that takes every result the input never stalls. When the receiver
// stalls, queued results hold and the input stops once fewer than two
// entries are free.
// Reset (rst_n low, synchronous) empties the queue, clears the stored
// timestamp and returns the parser to looking for a tag header.
// ----------------------------------------------------------------------------
module id3_priv_timestamp_parser_unit
  import id3pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] timestamp
  output logic [2:0]  out_tuser,  // [1:0] status, [2] timestamp_new
  output logic        out_tlast   // last_result
);

  phase_t       phase_r, phase_nxt;
  logic [5:0]   idx_r, idx_nxt;
  logic [31:0]  tag_rem_r, tag_rem_nxt;
  logic [31:0]  skip_r, skip_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic         match_r, match_nxt;
  logic         owner_r, owner_nxt;
  logic [63:0]  ts_r, ts_nxt;
  logic         loaded_r, loaded_nxt;

  out_item_t             q_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]     cnt_r;

  logic        in_fire, out_fire;
  logic [1:0]  n_emit;
  out_item_t   e0, e1;
  logic        fd;
  logic [31:0] fd_rem;
  logic [31:0] fsize;
  logic [1:0]  i2;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;
  assign i2       = idx_r[1:0];

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    tag_rem_nxt = tag_rem_r;
    skip_nxt    = skip_r;
    acc_nxt     = acc_r;
    match_nxt   = match_r;
    owner_nxt   = owner_r;
    ts_nxt      = ts_r;
    loaded_nxt  = loaded_r;
    n_emit      = 2'd0;
    e0          = '0;
    e1          = '0;
    fd          = 1'b0;
    fd_rem      = tag_rem_r;
    fsize       = 32'd0;

    if (in_tlast) begin
      e0.fresh = loaded_r;
      e0.last  = 1'b1;
      case (phase_r)
        PH_HEADER: begin
          e0.status = ST_NO_TAG;
          n_emit    = 2'd1;
        end
        PH_FRAME, PH_BODY: begin
          e0.status = ST_TRUNCATED;
          n_emit    = 2'd1;
        end
        PH_SKIP: begin
          if (tag_rem_r > 32'(HDR_LEN)) begin
            e0.status = ST_TRUNCATED;
            n_emit    = 2'd1;
          end else begin
            // skip counts as done, then the next header cannot be read
            e0.status = ST_TAG_OK;
            e0.last   = 1'b0;
            e1.status = ST_NO_TAG;
            e1.fresh  = 1'b0;
            e1.last   = 1'b1;
            n_emit    = 2'd2;
          end
        end
        default: n_emit = 2'd0;
      endcase
      phase_nxt   = PH_HEADER;
      idx_nxt     = '0;
      acc_nxt     = '0;
      match_nxt   = 1'b1;
      owner_nxt   = 1'b1;
      loaded_nxt  = 1'b0;
      tag_rem_nxt = '0;
      skip_nxt    = '0;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (idx_r < 6'd3 && in_tdata != magic_byte(i2)) match_nxt = 1'b0;
          // tag size: 7 bits per byte, no masking of the top bit
          if (idx_r >= 6'd6) acc_nxt = (acc_r << 7) | {56'd0, in_tdata};
          if (idx_r < 6'(HDR_LEN - 1)) begin
            idx_nxt = idx_r + 6'd1;
          end else if (!match_nxt) begin
            e0.status = ST_NO_TAG;
            e0.fresh  = loaded_r;
            e0.last   = 1'b1;
            n_emit    = 2'd1;
            phase_nxt = PH_HALT;
          end else begin
            tag_rem_nxt = acc_nxt[31:0];
            fd          = 1'b1;
            fd_rem      = acc_nxt[31:0];
          end
        end
        PH_FRAME: begin
          if (idx_r < 6'd4 && in_tdata != priv_byte(i2)) match_nxt = 1'b0;
          if (idx_r >= 6'd4 && idx_r < 6'd8)
            acc_nxt = (acc_r << 8) | {56'd0, in_tdata};
          if (idx_r < 6'(HDR_LEN - 1)) begin
            idx_nxt = idx_r + 6'd1;
          end else begin
            fsize       = acc_nxt[31:0];
            tag_rem_nxt = tag_rem_r - (32'(HDR_LEN) + fsize);
            idx_nxt     = '0;
            acc_nxt     = '0;
            if (match_nxt && fsize == 32'(PRIV_LEN)) begin
              phase_nxt = PH_BODY;
              owner_nxt = 1'b1;
            end else begin
              skip_nxt = fsize;
              if (fsize == 32'd0) begin
                fd     = 1'b1;
                fd_rem = tag_rem_nxt;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_BODY: begin
          if (idx_r < 6'(OWNER_LEN)) begin
            if (in_tdata != owner_byte(idx_r)) owner_nxt = 1'b0;
          end else if (idx_r == 6'(OWNER_LEN)) begin
            if (in_tdata != 8'd0) owner_nxt = 1'b0;
          end else begin
            acc_nxt = (acc_r << 8) | {56'd0, in_tdata};
          end
          if (idx_r < 6'(PRIV_LEN - 1)) begin
            idx_nxt = idx_r + 6'd1;
          end else begin
            if (owner_nxt) begin
              ts_nxt     = acc_nxt;
              loaded_nxt = 1'b1;
            end
            fd = 1'b1;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_nxt == 32'd0) fd = 1'b1;
        end
        default: n_emit = 2'd0;
      endcase

      // frame finished: next frame header, or close the tag
      if (fd) begin
        if (fd_rem > 32'(HDR_LEN)) begin
          phase_nxt = PH_FRAME;
          idx_nxt   = '0;
          acc_nxt   = '0;
          match_nxt = 1'b1;
        end else begin
          e0.status  = ST_TAG_OK;
          e0.fresh   = loaded_nxt;
          e0.last    = 1'b1;
          n_emit     = 2'd1;
          phase_nxt  = PH_HEADER;
          idx_nxt    = '0;
          acc_nxt    = '0;
          match_nxt  = 1'b1;
          owner_nxt  = 1'b1;
          loaded_nxt = 1'b0;
        end
      end
    end
    e0.ts = ts_nxt;
    e1.ts = ts_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      idx_r     <= '0;
      tag_rem_r <= '0;
      skip_r    <= '0;
      acc_r     <= '0;
      match_r   <= 1'b1;
      owner_r   <= 1'b1;
      ts_r      <= '0;
      loaded_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      tag_rem_r <= tag_rem_nxt;
      skip_r    <= skip_nxt;
      acc_r     <= acc_nxt;
      match_r   <= match_nxt;
      owner_r   <= owner_nxt;
      ts_r      <= ts_nxt;
      loaded_r  <= loaded_nxt;
    end
  end

  // result queue: up to two pushes and one pop per cycle
  logic [1:0]        push_n;
  logic [QPTR_W-1:0] wr_ptr_p1;

  assign push_n    = in_fire ? n_emit : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (out_fire) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push_n) - QCNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= e0;
    if (push_n == 2'd2) q_r[wr_ptr_p1] <= e1;
  end

  assign in_tready  = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_r[rd_ptr_r].ts;
  assign out_tuser  = {q_r[rd_ptr_r].fresh, q_r[rd_ptr_r].status};
  assign out_tlast  = q_r[rd_ptr_r].last;

endmodule

### tb/id3_priv_timestamp_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// id3_priv_timestamp_parser_unit_tb
// Streams ID3 tags, PRIV timestamp frames, other frames, noise and
// truncated streams into the parser and checks each status result against a
// byte-level parser model kept in the bench, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module id3_priv_timestamp_parser_unit_tb;
  import id3pts_pkg::*;

  localparam logic [1:0] ST_NONE = 2'd3;  // table marker: row causes no result
  localparam int STREAM_BYTES = 1750;
  localparam int LONG_HOLD    = 500;
  localparam int DIR_ROWS     = 26;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    logic [1:0] st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // parser model state
  phase_t      pr_phase;
  logic [5:0]  pr_idx;
  logic [31:0] pr_tag_left;
  logic [31:0] pr_skip_left;
  logic [63:0] pr_acc;
  logic [63:0] pr_ts;
  logic        pr_id_ok;
  logic        pr_owner_ok;
  logic        pr_ts_loaded;

  out_item_t   status_q[$];
  logic [7:0]  stream_q[$];
  logic [7:0]  frame_q[$];

  int errors = 0;
  int sent_cnt = 0;
  int result_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_mix[4] = '{0, 56, 0, 29};
  int stall_mix[4] = '{0, 0, 56, 29};

  dir_row_t dir_tab[DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, ST_NO_TAG},     // end of stream right after reset
    '{8'h49, 1'b0, 1'b0, ST_NONE},       // "ID4": bad magic
    '{8'h44, 1'b0, 1'b0, ST_NONE},
    '{8'h34, 1'b0, 1'b0, ST_NONE},
    '{8'hFF, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b0, 1'b0, ST_NONE},
    '{8'h80, 1'b0, 1'b0, ST_NONE},
    '{8'h7F, 1'b0, 1'b0, ST_NONE},
    '{8'hFF, 1'b0, 1'b0, ST_NONE},
    '{8'h01, 1'b0, 1'b0, ST_NONE},
    '{8'hFF, 1'b0, 1'b1, ST_NO_TAG},
    '{8'hFF, 1'b0, 1'b1, ST_NONE},       // halted: byte ignored
    '{8'hA5, 1'b1, 1'b1, ST_NONE},       // halted end of stream re-arms silently
    '{8'h49, 1'b0, 1'b0, ST_NONE},       // partial header, then end of stream
    '{8'h44, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b1, 1'b1, ST_NO_TAG},
    '{8'h49, 1'b0, 1'b0, ST_NONE},       // empty tag, size zero
    '{8'h44, 1'b0, 1'b0, ST_NONE},
    '{8'h33, 1'b0, 1'b0, ST_NONE},
    '{8'h04, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b0, 1'b0, ST_NONE},
    '{8'h00, 1'b0, 1'b1, ST_TAG_OK}
  };

  id3_priv_timestamp_parser_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void push_status(logic [1:0] st, logic fresh, logic last);
    status_q.push_back('{ts: pr_ts, status: st, fresh: fresh, last: last});
    result_cnt++;
  endfunction

  function automatic void restart_header();
    pr_phase     = PH_HEADER;
    pr_idx       = '0;
    pr_acc       = '0;
    pr_id_ok     = 1'b1;
    pr_owner_ok  = 1'b1;
    pr_ts_loaded = 1'b0;
  endfunction

  function automatic void close_frame();
    if (pr_tag_left > HDR_LEN) begin
      pr_phase = PH_FRAME;
      pr_idx   = '0;
      pr_acc   = '0;
      pr_id_ok = 1'b1;
    end else begin
      push_status(ST_TAG_OK, pr_ts_loaded, 1'b1);
      restart_header();
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eos);
    int k;
    logic [31:0] fsize;
    k = pr_idx;
    if (eos) begin
      case (pr_phase)
        PH_HEADER: push_status(ST_NO_TAG, pr_ts_loaded, 1'b1);
        PH_FRAME, PH_BODY: push_status(ST_TRUNCATED, pr_ts_loaded, 1'b1);
        PH_SKIP: begin
          // skip counts as done; a closed tag is followed by a header that never comes
          if (pr_tag_left > HDR_LEN) begin
            push_status(ST_TRUNCATED, pr_ts_loaded, 1'b1);
          end else begin
            push_status(ST_TAG_OK, pr_ts_loaded, 1'b0);
            push_status(ST_NO_TAG, 1'b0, 1'b1);
          end
        end
        default: ;
      endcase
      restart_header();
      pr_tag_left  = '0;
      pr_skip_left = '0;
      return;
    end
    case (pr_phase)
      PH_HEADER: begin
        if (k < 3 && b != MAGIC_STR[23 - 8*k -: 8]) pr_id_ok = 1'b0;
        // size bytes shift in 7 bits each, high bit not masked
        if (k >= 6) pr_acc = (pr_acc << 7) | 64'(b);
        if (k < HDR_LEN - 1) begin
          pr_idx = 6'(k + 1);
          return;
        end
        if (!pr_id_ok) begin
          push_status(ST_NO_TAG, pr_ts_loaded, 1'b1);
          pr_phase = PH_HALT;
        end else begin
          pr_tag_left = pr_acc[31:0];
          close_frame();
        end
      end
      PH_FRAME: begin
        if (k < 4 && b != PRIV_STR[31 - 8*k -: 8]) pr_id_ok = 1'b0;
        if (k >= 4 && k < 8) pr_acc = (pr_acc << 8) | 64'(b);
        if (k < HDR_LEN - 1) begin
          pr_idx = 6'(k + 1);
          return;
        end
        fsize       = pr_acc[31:0];
        pr_tag_left = pr_tag_left - (32'(HDR_LEN) + fsize);
        pr_idx      = '0;
        pr_acc      = '0;
        if (pr_id_ok && fsize == PRIV_LEN) begin
          pr_phase    = PH_BODY;
          pr_owner_ok = 1'b1;
        end else begin
          pr_skip_left = fsize;
          if (fsize == 0) close_frame();
          else pr_phase = PH_SKIP;
        end
      end
      PH_BODY: begin
        if (k < OWNER_LEN) begin
          if (b != OWNER_STR[8*OWNER_LEN - 1 - 8*k -: 8]) pr_owner_ok = 1'b0;
        end else if (k == OWNER_LEN) begin
          if (b != 8'h00) pr_owner_ok = 1'b0;
        end else begin
          pr_acc = (pr_acc << 8) | 64'(b);
        end
        if (k < PRIV_LEN - 1) begin
          pr_idx = 6'(k + 1);
          return;
        end
        if (pr_owner_ok) begin
          pr_ts        = pr_acc;
          pr_ts_loaded = 1'b1;
        end
        close_frame();
      end
      PH_SKIP: begin
        pr_skip_left = pr_skip_left - 1;
        if (pr_skip_left == 0) close_frame();
      end
      default: ;
    endcase
  endfunction

  // append one frame: mostly PRIV timestamp frames, some spoiled, some other frames
  function automatic void add_frame();
    int pick;
    int base;
    logic [31:0] fid;
    logic [31:0] fsize;
    logic [63:0] tsv;
    pick  = $urandom_range(99);
    fid   = PRIV_STR;
    fsize = PRIV_LEN;
    if (pick == 99) begin
      fid   = $urandom;
      fsize = {1'b1, 31'($urandom)};
    end else if (pick >= 95) begin
      fid   = $urandom;
      fsize = $urandom_range(24);
    end else if (pick >= 60) begin
      fid   = "TXXX";
      fsize = $urandom_range(24);
    end else if (pick >= 55) begin
      fsize = $urandom_range(1) ? PRIV_LEN - 1 : PRIV_LEN + 1;
    end else if (pick >= 50) begin
      fid ^= 32'h1 << $urandom_range(31);
    end
    for (int k = 0; k < 4; k++) frame_q.push_back(fid[31 - 8*k -: 8]);
    for (int k = 0; k < 4; k++) frame_q.push_back(fsize[31 - 8*k -: 8]);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    if (pick == 99) return;  // huge frame: body never sent, stream ends mid-skip
    base = frame_q.size();
    if (fsize == PRIV_LEN) begin
      case ($urandom_range(9))
        0:       tsv = '0;
        1:       tsv = '1;
        default: tsv = {$urandom, $urandom};
      endcase
      for (int k = 0; k < OWNER_LEN; k++)
        frame_q.push_back(OWNER_STR[8*OWNER_LEN - 1 - 8*k -: 8]);
      frame_q.push_back(8'h00);
      for (int k = 0; k < 8; k++) frame_q.push_back(tsv[63 - 8*k -: 8]);
      // spoil the owner string or its terminator
      if (pick >= 40 && pick < 50)
        frame_q[base + $urandom_range(OWNER_LEN)] ^= 8'h01 << $urandom_range(7);
    end else begin
      for (int k = 0; k < int'(fsize); k++) frame_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void build_tag();
    logic [23:0] hdr;
    logic [31:0] tsize;
    frame_q.delete();
    repeat ($urandom_range(3)) add_frame();
    // padding up to 10 closes the tag; more makes the parser read on
    tsize = frame_q.size() + (($urandom_range(99) < 75) ? $urandom_range(10)
                                                        : $urandom_range(40, 11));
    hdr = MAGIC_STR;
    if ($urandom_range(99) < 5) hdr ^= 24'h1 << $urandom_range(23);
    stream_q.delete();
    for (int k = 0; k < 3; k++) stream_q.push_back(hdr[23 - 8*k -: 8]);
    repeat (3) stream_q.push_back(8'($urandom));
    if ($urandom_range(99) < 8) begin
      repeat (4) stream_q.push_back(8'($urandom));
    end else begin
      stream_q.push_back({1'b0, tsize[27:21]});
      stream_q.push_back({1'b0, tsize[20:14]});
      stream_q.push_back({1'b0, tsize[13:7]});
      stream_q.push_back({1'b0, tsize[6:0]});
    end
    foreach (frame_q[k]) stream_q.push_back(frame_q[k]);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eos);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    parse_byte(b, eos);
    sent_cnt++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        $error("unexpected result transfer: status %0d timestamp %h",
               out_tuser[1:0], out_tdata);
        errors++;
      end else begin
        want = status_q.pop_front();
        if (out_tuser[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser[1:0]);
          errors++;
        end
        if (out_tdata !== want.ts) begin
          $error("timestamp: expected %h, got %h", want.ts, out_tdata);
          errors++;
        end
        if (out_tuser[2] !== want.fresh) begin
          $error("timestamp_new: expected %0d, got %0d", want.fresh, out_tuser[2]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("id3_priv_timestamp_parser_unit verification failed");
    $finish;
  end

  initial begin
    int prev_cnt;
    int pick;
    int cut;
    int goal;
    restart_header();
    pr_tag_left  = '0;
    pr_skip_left = '0;
    pr_ts        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      prev_cnt = result_cnt;
      send_item(dir_tab[r].data, dir_tab[r].eos);
      if (dir_tab[r].typed) begin
        repeat (result_cnt - prev_cnt) void'(status_q.pop_back());
        if (dir_tab[r].st != ST_NONE)
          status_q.push_back('{ts: 64'd0, status: dir_tab[r].st, fresh: 1'b0, last: 1'b1});
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      // hold the sender until every pending result is out
      in_tvalid <= 1'b0;
      do @(posedge clk); while (status_q.size() != 0);
      send_idle_pct  = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      if (ph == 0) hold_reqs++;
      goal = DIR_ROWS + (ph + 1) * STREAM_BYTES / 4;
      while (sent_cnt < goal) begin
        if (pr_phase == PH_HALT || (pr_phase == PH_SKIP && pr_skip_left > 64)) begin
          send_item(8'($urandom), 1'b1);
        end else begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            send_item(8'($urandom), 1'b1);
          end else if (pick < 12) begin
            repeat ($urandom_range(12, 1)) send_item(8'($urandom), 1'b0);
          end else begin
            build_tag();
            // truncate some tags to end the stream in every parse phase
            cut = (pick < 30) ? $urandom_range(stream_q.size() - 1) : stream_q.size();
            for (int k = 0; k < cut; k++) send_item(stream_q[k], 1'b0);
            if (cut < stream_q.size()) send_item(8'($urandom), 1'b1);
          end
        end
      end
    end

    recv_stall_pct = 0;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (status_q.size() != 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("id3_priv_timestamp_parser_unit verification clean");
    end else begin
      $display("id3_priv_timestamp_parser_unit verification failed");
    end
    $finish;
  end

endmodule
